// File: hw/rtl/chh_pkg.sv
// Package for the circular heat histogram: sizes, command codes and beat types.
// Used by chh_gen, chh_cell and circular_heat_histogram_argmin; depends on nothing.
`default_nettype none

package chh_pkg;

    // Geometry of the histogram.
    localparam int SEGMENTS    = 64;
    localparam int PITCH_SLOTS = 4;
    localparam int IDX_W       = $clog2(SEGMENTS);
    localparam int PSLOT_W     = (PITCH_SLOTS > 1) ? $clog2(PITCH_SLOTS) : 1;

    // Storage widths.
    localparam int HEAT_W    = 40;
    localparam int COUNT_W   = 24;
    localparam int CONTRIB_W = 15;

    // Yaw scale: 1/128 degree, so half a circle is 23040.
    localparam int YAW_HALF = 23040;
    localparam int YAW_FULL = 46080;

    // Bin centers are stepped as quotient and remainder of (2i+1)*YAW_HALF/SEGMENTS.
    localparam int CTR_Q0 = YAW_HALF / SEGMENTS;
    localparam int CTR_R0 = YAW_HALF % SEGMENTS;
    localparam int STEP_Q = YAW_FULL / SEGMENTS;
    localparam int STEP_R = YAW_FULL % SEGMENTS;

    // Division by 45 through a reciprocal, exact for dividends below 2^21.
    localparam int DIV45_SHIFT = 27;
    localparam int DIV45_MUL   = 2982617;

    // Command codes.
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // One input beat.
    typedef struct packed {
        logic [1:0]         command;
        logic [1:0]         pitch_slot;
        logic signed [15:0] hit_yaw;
        logic signed [15:0] threat;
    } chh_in_t;

    // One result beat.
    typedef struct packed {
        logic signed [15:0] safest_yaw;
        logic [5:0]         best_bin;
        logic               valid_res;
    } chh_out_t;

    // Bin index and center as stepped by the generator.
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [IDX_W-1:0]   idx;
        logic signed [15:0] center;
    } chh_scan_t;

    // Heat contribution for one bin.
    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic [CONTRIB_W-1:0] contrib;
    } chh_contrib_t;

    // Controls broadcast to every cell of the chain.
    typedef struct packed {
        logic               clear;
        logic               load;
        logic               shift;
        logic               commit;
        logic [PSLOT_W-1:0] slot;
    } chh_cell_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/circular_heat_histogram_argmin.sv
// Circular heat histogram with least-heat query. An add keeps busy high while
// the generator steps one bin per cycle and its contributions shift into the
// chain, then through one commit. A query of a slot with samples strobes done
// once the bins have been shifted out of the cell chain, one per cycle.
// Clear, an empty query and ignored commands never raise busy.
// rst_n clears all bins and counters at once; done cannot be held off.
`default_nettype none

module circular_heat_histogram_argmin (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  chh_pkg::chh_in_t  item,
    output logic              busy,
    output logic              done,
    output chh_pkg::chh_out_t result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_COMMIT
    } state_t;

    state_t                          state_reg;
    logic                            done_reg;
    chh_pkg::chh_out_t               result_reg;

    logic                            add_reg;
    logic [chh_pkg::PSLOT_W-1:0]     slot_reg;
    logic signed [15:0]              yaw_reg;
    logic [chh_pkg::CONTRIB_W-1:0]   threat_reg;
    logic [chh_pkg::COUNT_W-1:0]     count_reg [chh_pkg::PITCH_SLOTS];

    logic                            accept;
    logic                            slot_ok;
    logic [chh_pkg::PSLOT_W-1:0]     item_slot;
    logic [chh_pkg::COUNT_W-1:0]     item_count;
    logic                            add_ok;
    logic                            query_scan;
    logic                            query_empty;
    logic                            do_clear;
    logic signed [16:0]              yaw_ext;
    logic signed [16:0]              yaw_wrap;

    chh_pkg::chh_scan_t              gen_scan;
    chh_pkg::chh_contrib_t           gen_contrib;
    chh_pkg::chh_cell_ctl_t          cell_ctl;
    logic [chh_pkg::HEAT_W-1:0]      lane_w [chh_pkg::SEGMENTS+1];

    logic [chh_pkg::HEAT_W-1:0]      min_reg;
    logic [chh_pkg::IDX_W-1:0]       best_idx_reg;
    logic signed [15:0]              best_ctr_reg;
    logic                            take;
    logic [chh_pkg::HEAT_W-1:0]      win_val;
    logic [chh_pkg::IDX_W-1:0]       win_idx;
    logic signed [15:0]              win_ctr;

    logic [15:0]                     inc_sum;
    logic [7:0]                      inc;
    logic [chh_pkg::COUNT_W:0]       count_sum;

    // Command decode on an accepted beat.
    assign accept      = start && !busy;
    assign slot_ok     = 32'(item.pitch_slot) < 32'(chh_pkg::PITCH_SLOTS);
    assign item_slot   = chh_pkg::PSLOT_W'(item.pitch_slot);
    assign item_count  = slot_ok ? count_reg[item_slot] : '0;
    assign add_ok      = (item.command == chh_pkg::CMD_ADD) && slot_ok &&
                         !item.threat[15] && (item.threat != 16'sd0);
    assign query_scan  = (item.command == chh_pkg::CMD_QUERY) && (item_count != '0);
    assign query_empty = (item.command == chh_pkg::CMD_QUERY) && (item_count == '0);
    assign do_clear    = accept && (item.command == chh_pkg::CMD_CLEAR);

    // Wrap the hit yaw into one turn around zero.
    always_comb
    begin
        yaw_ext = {item.hit_yaw[15], item.hit_yaw};
        if (yaw_ext < -17'sd23040)
        begin
            yaw_wrap = yaw_ext + 17'sd46080;
        end
        else if (yaw_ext >= 17'sd23040)
        begin
            yaw_wrap = yaw_ext - 17'sd46080;
        end
        else
        begin
            yaw_wrap = yaw_ext;
        end
    end

    // Operands held for the whole command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_reg <= 1'b0;
        end
        else if (accept)
        begin
            add_reg <= (item.command == chh_pkg::CMD_ADD);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg   <= item_slot;
            yaw_reg    <= yaw_wrap[15:0];
            threat_reg <= item.threat[chh_pkg::CONTRIB_W-1:0];
        end
    end

    // Bin generator and contribution pipeline.
    chh_gen u_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == ST_LOAD),
        .calc    (add_reg),
        .yaw     (yaw_reg),
        .threat  (threat_reg),
        .scan    (gen_scan),
        .contrib (gen_contrib)
    );

    // Controls shared by all cells.
    always_comb
    begin
        cell_ctl.clear  = do_clear;
        cell_ctl.load   = (state_reg == ST_LOAD) && !add_reg;
        cell_ctl.shift  = (state_reg == ST_RUN) &&
                          (add_reg ? gen_contrib.valid : gen_scan.valid);
        cell_ctl.commit = (state_reg == ST_COMMIT);
        cell_ctl.slot   = slot_reg;
    end

    // Cell chain: contributions enter at the top cell, bins leave at cell 0.
    assign lane_w[chh_pkg::SEGMENTS] = chh_pkg::HEAT_W'(gen_contrib.contrib);

    for (genvar k = 0; k < chh_pkg::SEGMENTS; k++)
    begin : g_cell
        chh_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (cell_ctl),
            .lane_in  (lane_w[k+1]),
            .lane_out (lane_w[k])
        );
    end

    // Running minimum over the bins leaving cell 0; ties keep the earlier bin.
    always_comb
    begin
        take = (gen_scan.idx == '0) || (lane_w[0] < min_reg);
        if (take)
        begin
            win_val = lane_w[0];
            win_idx = gen_scan.idx;
            win_ctr = gen_scan.center;
        end
        else
        begin
            win_val = min_reg;
            win_idx = best_idx_reg;
            win_ctr = best_ctr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_RUN) && !add_reg && gen_scan.valid)
        begin
            min_reg      <= win_val;
            best_idx_reg <= win_idx;
            best_ctr_reg <= win_ctr;
        end
    end

    // Weight counters, raised at commit by max(1, threat/256 rounded).
    assign inc_sum   = {1'b0, threat_reg} + 16'd128;
    assign inc       = (inc_sum[15:8] == 8'd0) ? 8'd1 : inc_sum[15:8];
    assign count_sum = {1'b0, count_reg[slot_reg]} + (chh_pkg::COUNT_W + 1)'(inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < chh_pkg::PITCH_SLOTS; s++)
            begin
                count_reg[s] <= '0;
            end
        end
        else if (do_clear)
        begin
            for (int s = 0; s < chh_pkg::PITCH_SLOTS; s++)
            begin
                count_reg[s] <= '0;
            end
        end
        else if (state_reg == ST_COMMIT)
        begin
            count_reg[slot_reg] <= count_sum[chh_pkg::COUNT_W] ? '1 :
                                   count_sum[chh_pkg::COUNT_W-1:0];
        end
    end

    // Sequencer with the result beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (add_ok || query_scan)
                        begin
                            state_reg <= ST_LOAD;
                        end
                        else if (query_empty)
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '0;
                        end
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    if (add_reg)
                    begin
                        if (gen_contrib.valid && gen_contrib.last)
                        begin
                            state_reg <= ST_COMMIT;
                        end
                    end
                    else if (gen_scan.valid && gen_scan.last)
                    begin
                        state_reg             <= ST_IDLE;
                        done_reg              <= 1'b1;
                        result_reg.safest_yaw <= win_ctr;
                        result_reg.best_bin   <= 6'(win_idx);
                        result_reg.valid_res  <= 1'b1;
                    end
                end
                ST_COMMIT:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // A result beat never overlaps a running command.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // The generator steps bins only inside a command.
    a_gen_busy: assert property (@(posedge clk) disable iff (!rst_n)
        gen_scan.valid |-> busy)
        else $error("generator running while idle");

    // Contributions arrive only while an add is shifting them into the chain.
    a_contrib_add: assert property (@(posedge clk) disable iff (!rst_n)
        gen_contrib.valid |-> ((state_reg == ST_RUN) && add_reg))
        else $error("contribution outside an add");

    // Commit follows directly on the last contribution.
    a_commit_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |-> $past(gen_contrib.valid && gen_contrib.last))
        else $error("commit without last contribution");

endmodule

`default_nettype wire

// File: hw/rtl/chh_gen.sv
// Bin generator: steps bin index and center one bin per cycle, then computes
// the heat contribution of a hit in a three-stage pipeline. Uses chh_pkg.
`default_nettype none

module chh_gen (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           calc,
    input  logic signed [15:0]             yaw,
    input  logic [chh_pkg::CONTRIB_W-1:0]  threat,
    output chh_pkg::chh_scan_t             scan,
    output chh_pkg::chh_contrib_t          contrib
);

    // Stage A: bin index and center.
    logic                        a_valid_reg;
    logic [chh_pkg::IDX_W-1:0]   idx_reg;
    logic [16:0]                 q_reg;
    logic [chh_pkg::IDX_W-1:0]   r_reg;
    logic [chh_pkg::IDX_W:0]     r_sum;
    logic [chh_pkg::IDX_W:0]     r_wrap;
    logic [16:0]                 q_step;
    logic                        a_last;

    // Stage B: weight 23040 - distance.
    logic                        b_valid_reg;
    logic                        b_last_reg;
    logic [14:0]                 w_reg;
    logic signed [16:0]          diff;
    logic [15:0]                 rdist;
    logic [15:0]                 arc_dist;
    logic [14:0]                 w_next;

    // Stage C: product with rounding offset.
    logic                        c_valid_reg;
    logic                        c_last_reg;
    logic [29:0]                 p_reg;
    logic [29:0]                 p_next;

    // Stage D: division by 23040.
    logic                        d_valid_reg;
    logic                        d_last_reg;
    logic [chh_pkg::CONTRIB_W-1:0] d_contrib_reg;
    logic [42:0]                 quot_prod;

    // Remainder step of the center quotient.
    always_comb
    begin
        r_sum = {1'b0, r_reg} + (chh_pkg::IDX_W + 1)'(chh_pkg::STEP_R);
        if (r_sum >= (chh_pkg::IDX_W + 1)'(chh_pkg::SEGMENTS))
        begin
            r_wrap = r_sum - (chh_pkg::IDX_W + 1)'(chh_pkg::SEGMENTS);
            q_step = 17'(chh_pkg::STEP_Q + 1);
        end
        else
        begin
            r_wrap = r_sum;
            q_step = 17'(chh_pkg::STEP_Q);
        end
    end

    assign a_last = (idx_reg == chh_pkg::IDX_W'(chh_pkg::SEGMENTS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (start)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_valid_reg && a_last)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            idx_reg <= '0;
            q_reg   <= 17'(chh_pkg::CTR_Q0);
            r_reg   <= chh_pkg::IDX_W'(chh_pkg::CTR_R0);
        end
        else if (a_valid_reg)
        begin
            idx_reg <= idx_reg + 1'b1;
            q_reg   <= q_reg + q_step;
            r_reg   <= r_wrap[chh_pkg::IDX_W-1:0];
        end
    end

    assign scan.valid  = a_valid_reg;
    assign scan.last   = a_last;
    assign scan.idx    = idx_reg;
    assign scan.center = 16'(q_reg - 17'(chh_pkg::YAW_HALF));

    // Circular distance from the bin center to the hit; the yaw is already
    // wrapped into one turn, so one correction brings the difference in range.
    always_comb
    begin
        diff     = {scan.center[15], scan.center} - {yaw[15], yaw};
        rdist    = diff[16] ? 16'(diff + 17'sd46080) : diff[15:0];
        arc_dist = (rdist > 16'(chh_pkg::YAW_HALF)) ? 16'(chh_pkg::YAW_FULL) - rdist : rdist;
        w_next   = 15'(16'(chh_pkg::YAW_HALF) - arc_dist);
    end

    assign p_next    = 30'(threat) * 30'(w_reg) + 30'(chh_pkg::YAW_HALF / 2);
    assign quot_prod = 43'(p_reg[29:9]) * 43'(chh_pkg::DIV45_MUL);

    // Pipeline valid chain; only an add calculates contributions.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_last_reg  <= 1'b0;
            c_valid_reg <= 1'b0;
            c_last_reg  <= 1'b0;
            d_valid_reg <= 1'b0;
            d_last_reg  <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg && calc;
            b_last_reg  <= a_last;
            c_valid_reg <= b_valid_reg;
            c_last_reg  <= b_last_reg;
            d_valid_reg <= c_valid_reg;
            d_last_reg  <= c_last_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        w_reg         <= w_next;
        p_reg         <= p_next;
        d_contrib_reg <= quot_prod[chh_pkg::DIV45_SHIFT + chh_pkg::CONTRIB_W - 1:
                                   chh_pkg::DIV45_SHIFT];
    end

    assign contrib.valid   = d_valid_reg;
    assign contrib.last    = d_last_reg;
    assign contrib.contrib = d_contrib_reg;

endmodule

`default_nettype wire

// File: hw/rtl/chh_cell.sv
// One histogram cell: the heat of one yaw bin for every pitch slot, plus a
// lane register that shifts toward cell 0. Uses chh_pkg.
`default_nettype none

module chh_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  chh_pkg::chh_cell_ctl_t       ctl,
    input  logic [chh_pkg::HEAT_W-1:0]   lane_in,
    output logic [chh_pkg::HEAT_W-1:0]   lane_out
);

    logic [chh_pkg::HEAT_W-1:0] bin_reg [chh_pkg::PITCH_SLOTS];
    logic [chh_pkg::HEAT_W-1:0] lane_reg;
    logic [chh_pkg::HEAT_W:0]   sum;
    logic [chh_pkg::HEAT_W-1:0] sat;

    // Saturating add of the lane contribution to the addressed bin.
    assign sum = {1'b0, bin_reg[ctl.slot]} + {1'b0, lane_reg};
    assign sat = sum[chh_pkg::HEAT_W] ? '1 : sum[chh_pkg::HEAT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < chh_pkg::PITCH_SLOTS; s++)
            begin
                bin_reg[s] <= '0;
            end
        end
        else if (ctl.clear)
        begin
            for (int s = 0; s < chh_pkg::PITCH_SLOTS; s++)
            begin
                bin_reg[s] <= '0;
            end
        end
        else if (ctl.commit)
        begin
            bin_reg[ctl.slot] <= sat;
        end
    end

    // Lane: a copy of the bin for a query, or a passing contribution for an add.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            lane_reg <= bin_reg[ctl.slot];
        end
        else if (ctl.shift)
        begin
            lane_reg <= lane_in;
        end
    end

    assign lane_out = lane_reg;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for circular_heat_histogram_argmin: a directed table and then
// random commands. Rows with a typed answer are checked against it; all other answers
// against a behavioral heat-map model. Depends on chh_pkg and the block's RTL.

module tb_top;
    import chh_pkg::*;

    // Command code that the package leaves unnamed; the block ignores it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_TARGET = 1900;
    localparam int QUIET_TAIL    = 200;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = SEGMENTS + 16;
    localparam int DIRECTED_ROWS = 22;

    localparam logic [HEAT_W-1:0]  HEAT_CEIL  = '1;
    localparam logic [COUNT_W-1:0] COUNT_CEIL = '1;

    // One row of the directed table; the answer is typed in only where has_answer is set.
    typedef struct packed {
        logic [1:0]         command;
        logic [1:0]         pitch_slot;
        logic signed [15:0] hit_yaw;
        logic signed [15:0] threat;
        logic               has_answer;
        logic signed [15:0] answer_yaw;
        logic [5:0]         answer_bin;
        logic               answer_valid;
    } table_row_t;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    chh_in_t   item  = '0;
    logic      busy;
    logic      done;
    chh_out_t  result;

    // Model state: heat per slot and bin, and the weight tally per slot.
    logic [HEAT_W-1:0]  heat_map [PITCH_SLOTS][SEGMENTS];
    logic [COUNT_W-1:0] weight_tally [PITCH_SLOTS];

    chh_out_t pending_answers [$];
    chh_out_t oldest;
    int       mismatches       = 0;
    int       answers_checked  = 0;
    int       empty_answers    = 0;
    int       commands_taken   = 0;
    int       cycle_count      = 0;

    table_row_t directed [DIRECTED_ROWS] = '{
        // Queries of slots that never saw a sample.
        '{CMD_QUERY, 2'd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 6'd0, 1'b0},
        '{CMD_QUERY, 2'd3, 16'sd0, 16'sd0, 1'b1, 16'sd0, 6'd0, 1'b0},
        // A hit at yaw 0 leaves the bins at both edges coolest; the first one wins the tie.
        '{CMD_ADD,   2'd0, 16'sd0, 16'sd256, 1'b0, 16'sd0, 6'd0, 1'b0},
        '{CMD_QUERY, 2'd0, 16'sd0, 16'sd0, 1'b1, -16'sd22680, 6'd0, 1'b1},
        // A hit at +180 degrees with the largest threat: the middle bins tie.
        '{CMD_ADD,   2'd1, 16'sd23040, 16'sh7FFF, 1'b0, 16'sd0, 6'd0, 1'b0},
        '{CMD_QUERY, 2'd1, 16'sd0, 16'sd0, 1'b1, -16'sd360, 6'd31, 1'b1},
        // Most negative yaw wraps; the smallest threat still counts one sample.
        '{CMD_ADD,   2'd2, 16'sh8000, 16'sd1, 1'b0, 16'sd0, 6'd0, 1'b0},
        '{CMD_QUERY, 2'd2, 16'sd0, 16'sd0, 1'b0, 16'sd0, 6'd0, 1'b0},
        // Zero and most negative threats are dropped, so slot 3 stays empty.
        '{CMD_ADD,   2'd3, 16'sh7FFF, 16'sd0, 1'b0, 16'sd0, 6'd0, 1'b0},
        '{CMD_ADD,   2'd3, 16'sd100, 16'sh8000, 1'b0, 16'sd0, 6'd0, 1'b0},
        '{CMD_QUERY, 2'd3, 16'sd0, 16'sd0, 1'b1, 16'sd0, 6'd0, 1'b0},
        '{CMD_UNUSED, 2'd3, -16'sd1, -16'sd1, 1'b0, 16'sd0, 6'd0, 1'b0},
        '{CMD_ADD,   2'd3, -16'sd23040, 16'sd128, 1'b0, 16'sd0, 6'd0, 1'b0},
        '{CMD_QUERY, 2'd3, 16'sd0, 16'sd0, 1'b0, 16'sd0, 6'd0, 1'b0},
        '{CMD_ADD,   2'd0, 16'sd11520, 16'sd384, 1'b0, 16'sd0, 6'd0, 1'b0},
        '{CMD_QUERY, 2'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 6'd0, 1'b0},
        // Clear empties every slot.
        '{CMD_CLEAR, 2'd1, 16'sh7FFF, 16'sh7FFF, 1'b0, 16'sd0, 6'd0, 1'b0},
        '{CMD_QUERY, 2'd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 6'd0, 1'b0},
        '{CMD_QUERY, 2'd1, 16'sd0, 16'sd0, 1'b1, 16'sd0, 6'd0, 1'b0},
        // A hit on a bin center puts bin 0 exactly 180 degrees away: it gains nothing.
        '{CMD_ADD,   2'd2, 16'sd360, 16'sd256, 1'b0, 16'sd0, 6'd0, 1'b0},
        '{CMD_QUERY, 2'd2, 16'sd0, 16'sd0, 1'b1, -16'sd22680, 6'd0, 1'b1},
        '{CMD_QUERY, 2'd1, 16'sd0, 16'sd0, 1'b1, 16'sd0, 6'd0, 1'b0}
    };

    circular_heat_histogram_argmin dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #2 clk = ~clk;

    // Center yaw of a bin, in 1/128 degree.
    function automatic int bin_yaw(input int idx);
        return -YAW_HALF + ((2 * idx + 1) * YAW_HALF) / SEGMENTS;
    endfunction

    // Distance around the circle between two yaws.
    function automatic int arc_distance(input int a, input int b);
        int r;
        r = (a - b) % YAW_FULL;
        if (r < 0)
            r += YAW_FULL;
        return (r > YAW_HALF) ? YAW_FULL - r : r;
    endfunction

    // Spread one threat sample over the bins of a slot and bump its tally.
    task automatic deposit_heat(input int slot, input int yaw, input int threat);
        longint             share;
        logic [HEAT_W:0]    heat_sum;
        logic [COUNT_W:0]   tally_sum;
        int                 bump;
        for (int i = 0; i < SEGMENTS; i++)
        begin
            share = (longint'(threat) * longint'(YAW_HALF - arc_distance(bin_yaw(i), yaw))
                     + YAW_HALF / 2) / YAW_HALF;
            heat_sum = {1'b0, heat_map[slot][i]} + (HEAT_W + 1)'(share);
            heat_map[slot][i] = heat_sum[HEAT_W] ? HEAT_CEIL : heat_sum[HEAT_W-1:0];
        end
        bump = (threat + 128) >>> 8;
        if (bump < 1)
            bump = 1;
        tally_sum = {1'b0, weight_tally[slot]} + (COUNT_W + 1)'(bump);
        weight_tally[slot] = tally_sum[COUNT_W] ? COUNT_CEIL : tally_sum[COUNT_W-1:0];
    endtask

    // Apply one accepted command to the model; a query yields the coolest bin.
    task automatic predict_command(input chh_in_t b, output bit answers, output chh_out_t ans);
        int coolest;
        int slot;
        answers = 1'b0;
        ans     = '0;
        slot    = int'(b.pitch_slot);
        case (b.command)
            CMD_ADD:
            begin
                if (b.threat > 0 && slot < PITCH_SLOTS)
                    deposit_heat(slot, int'(b.hit_yaw), int'(b.threat));
            end
            CMD_CLEAR:
            begin
                for (int s = 0; s < PITCH_SLOTS; s++)
                begin
                    weight_tally[s] = '0;
                    for (int i = 0; i < SEGMENTS; i++)
                        heat_map[s][i] = '0;
                end
            end
            CMD_QUERY:
            begin
                answers = 1'b1;
                if (slot < PITCH_SLOTS && weight_tally[slot] != '0)
                begin
                    coolest = 0;
                    for (int i = 1; i < SEGMENTS; i++)
                        if (heat_map[slot][i] < heat_map[slot][coolest])
                            coolest = i;
                    ans.safest_yaw = 16'(bin_yaw(coolest));
                    ans.best_bin   = 6'(coolest);
                    ans.valid_res  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Random command: adds and queries dominate, clears are rare so heat builds up.
    function automatic chh_in_t random_command();
        chh_in_t b;
        int      pick;
        b.pitch_slot = 2'($urandom_range(0, 3));
        b.hit_yaw    = 16'($urandom);
        b.threat     = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            b.command = CMD_ADD;
            if ($urandom_range(0, 5) != 0)
                b.hit_yaw = 16'(int'($urandom_range(0, YAW_FULL)) - YAW_HALF);
            pick = $urandom_range(0, 9);
            if (pick < 3)
                b.threat = 16'($urandom_range(1, 600));
            else if (pick < 8)
                b.threat = 16'($urandom_range(1, 32767));
            // Otherwise the full-range threat stays, so zero and negative ones show up.
        end
        else if (pick < 90)
            b.command = CMD_QUERY;
        else if (pick < 93)
            b.command = CMD_CLEAR;
        else
            b.command = CMD_UNUSED;
        return b;
    endfunction

    // Present one beat, hold it until the block takes it, then update the model.
    task automatic issue_command(input chh_in_t b, input bit typed, input chh_out_t typed_ans);
        bit       answers;
        chh_out_t ans;
        start <= 1'b1;
        item  <= b;
        do
            @(posedge clk);
        while (busy);
        predict_command(b, answers, ans);
        if (answers)
            pending_answers.push_back(typed ? typed_ans : ans);
        commands_taken++;
    endtask

    // Sender gap: a random burst of idle cycles now and then.
    task automatic sender_gap(input bit allowed);
        if (allowed && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Stimulus: reset, directed table, then random commands.
    initial
    begin
        chh_in_t  b;
        chh_out_t typed_ans;
        int       effective;
        bit       calm;
        for (int s = 0; s < PITCH_SLOTS; s++)
        begin
            weight_tally[s] = '0;
            for (int i = 0; i < SEGMENTS; i++)
                heat_map[s][i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[r])
        begin
            b.command            = directed[r].command;
            b.pitch_slot         = directed[r].pitch_slot;
            b.hit_yaw            = directed[r].hit_yaw;
            b.threat             = directed[r].threat;
            typed_ans.safest_yaw = directed[r].answer_yaw;
            typed_ans.best_bin   = directed[r].answer_bin;
            typed_ans.valid_res  = directed[r].answer_valid;
            issue_command(b, directed[r].has_answer, typed_ans);
            sender_gap(1'b1);
        end

        // Random part; ignored commands do not count toward the target.
        effective = 0;
        calm      = 1'b0;
        while (effective < RANDOM_TARGET)
        begin
            if (effective % 50 == 0)
                calm = ($urandom_range(0, 2) == 0);
            b = random_command();
            issue_command(b, 1'b0, '0);
            if ((b.command == CMD_ADD && b.threat > 0) || b.command == CMD_QUERY
                || b.command == CMD_CLEAR)
                effective++;
            sender_gap(!calm && effective < RANDOM_TARGET - QUIET_TAIL);
        end
        start <= 1'b0;

        // Drain: wait for the last answers, then watch for stray strobes.
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb_top: %0d commands taken, %0d answers checked (%0d from empty slots)",
                 commands_taken, answers_checked, empty_answers);
        $display("tb_top: %0d mismatches in %0d cycles", mismatches, cycle_count);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Answer checker: every strobe must match the oldest outstanding query.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: answer with no query outstanding: yaw %0d bin %0d valid %0b",
                         $time, result.safest_yaw, result.best_bin, result.valid_res);
                mismatches++;
            end
            else
            begin
                oldest = pending_answers.pop_front();
                answers_checked++;
                if (!oldest.valid_res)
                    empty_answers++;
                if (result.safest_yaw !== oldest.safest_yaw)
                begin
                    $display("%0t: safest_yaw expected %0d, got %0d",
                             $time, oldest.safest_yaw, result.safest_yaw);
                    mismatches++;
                end
                if (result.best_bin !== oldest.best_bin)
                begin
                    $display("%0t: best_bin expected %0d, got %0d",
                             $time, oldest.best_bin, result.best_bin);
                    mismatches++;
                end
                if (result.valid_res !== oldest.valid_res)
                begin
                    $display("%0t: valid_res expected %0b, got %0b",
                             $time, oldest.valid_res, result.valid_res);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, pending_answers.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

endmodule

// File: circular_heat_histogram_argmin.f
hw/rtl/chh_pkg.sv
hw/rtl/chh_gen.sv
hw/rtl/chh_cell.sv
hw/rtl/circular_heat_histogram_argmin.sv
verif/tb_top.sv
